// File: design/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, constants and the projection function for the quantifier
// projection engine.
// ----------------------------------------------------------------------------
package qpe_pkg;

    localparam int MAX_QUANTIFIERS = 8;
    localparam int MAX_TOKENS      = 32;

    localparam int IDX_W  = $clog2(MAX_QUANTIFIERS);
    localparam int CNT_W  = $clog2(MAX_QUANTIFIERS + 1);
    localparam int SPAN_W = 6;
    localparam int CLS_W  = 4;
    localparam int REL_W  = 3;
    localparam int TOK_W  = 5;
    localparam int ENTRY_W = 4 * SPAN_W + 2 * CLS_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [REL_W-1:0] REL_NEGATION    = 3'd3;
    localparam logic [REL_W-1:0] REL_ALTERNATION = 3'd4;
    localparam logic [REL_W-1:0] REL_COVER       = 3'd5;
    localparam logic [REL_W-1:0] REL_INDEP       = 3'd6;
    localparam logic [CLS_W-1:0] CLASS_FLAT      = 4'd8;

    typedef struct packed {
        logic              opcode;
        logic [2:0]        entry_slot;
        logic [SPAN_W-1:0] subject_begin;
        logic [SPAN_W-1:0] subject_end;
        logic [SPAN_W-1:0] object_begin;
        logic [SPAN_W-1:0] object_end;
        logic [CLS_W-1:0]  subject_class;
        logic [CLS_W-1:0]  object_class;
        logic [TOK_W-1:0]  token_position;
        logic [REL_W-1:0]  lexical_relation;
        logic              end_truth;
    } t_item;

    typedef struct packed {
        logic [REL_W-1:0] projected_relation;
        logic             begin_truth;
        logic [3:0]       scope_count;
    } t_result;

    // Sequencer program addresses.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD,
        ST_EMIT
    } t_step;

    // Jump conditions of a control word.
    typedef enum logic [1:0] {
        J_GOTO,
        J_DISPATCH,
        J_WHILE_SCAN,
        J_WHILE_FOLD
    } t_jcond;

    typedef struct packed {
        logic   idle;
        logic   scan;
        logic   fold;
        logic   emit;
        t_jcond jcond;
        t_step  target;
    } t_uword;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic fold;
        logic emit;
    } t_ctl;

    // Loop status from the datapath to the sequencer.
    typedef struct packed {
        logic scan_more;
        logic fold_more;
    } t_status;

    localparam logic [REL_W-1:0] PROJ_TABLE [0:8][0:6] = '{
        '{3'd0, 3'd1, 3'd2, 3'd6, 3'd6, 3'd6, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd5, 3'd6, 3'd5, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd4, 3'd4, 3'd6, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd6, 3'd6, 3'd6, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd4, 3'd6, 3'd4, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd5, 3'd5, 3'd6, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd5, 3'd4, 3'd6},
        '{3'd0, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6}
    };

    // Unknown classes act as flat, an unknown relation as independence.
    function automatic logic [REL_W-1:0] proj_apply(input logic [CLS_W-1:0] cls,
                                                    input logic [REL_W-1:0] rel);
        logic [CLS_W-1:0] c;
        logic [REL_W-1:0] r;
        c = (cls > CLASS_FLAT) ? CLASS_FLAT : cls;
        r = (rel > REL_INDEP) ? REL_INDEP : rel;
        return PROJ_TABLE[c][r];
    endfunction

endpackage

// File: design/qpe_ram.sv
// ----------------------------------------------------------------------------
// qpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/qpe_seq.sv
// ----------------------------------------------------------------------------
// qpe_seq
// Microcode sequencer: step register, control ROM and jump logic.
// ----------------------------------------------------------------------------
module qpe_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_opcode,
    input  qpe_pkg::t_status i_status,
    output qpe_pkg::t_ctl    o_ctl,
    output logic             o_busy
);

    qpe_pkg::t_step  r_step;
    qpe_pkg::t_step  n_step;
    qpe_pkg::t_uword uw;

    // Control ROM: one word per step.
    function automatic qpe_pkg::t_uword ucode(input qpe_pkg::t_step s);
        qpe_pkg::t_uword w;
        w = '0;
        unique case (s)
            qpe_pkg::ST_IDLE: begin
                w.idle   = 1'b1;
                w.jcond  = qpe_pkg::J_DISPATCH;
                w.target = qpe_pkg::ST_SCAN;
            end
            qpe_pkg::ST_SCAN: begin
                w.scan   = 1'b1;
                w.jcond  = qpe_pkg::J_WHILE_SCAN;
                w.target = qpe_pkg::ST_FOLD;
            end
            qpe_pkg::ST_FOLD: begin
                w.fold   = 1'b1;
                w.jcond  = qpe_pkg::J_WHILE_FOLD;
                w.target = qpe_pkg::ST_EMIT;
            end
            qpe_pkg::ST_EMIT: begin
                w.emit   = 1'b1;
                w.jcond  = qpe_pkg::J_GOTO;
                w.target = qpe_pkg::ST_IDLE;
            end
            default: begin
                w.jcond  = qpe_pkg::J_GOTO;
                w.target = qpe_pkg::ST_IDLE;
            end
        endcase
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= qpe_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uw     = ucode(r_step);
        n_step = r_step;
        unique case (uw.jcond)
            qpe_pkg::J_GOTO: begin
                n_step = uw.target;
            end
            qpe_pkg::J_DISPATCH: begin
                if (i_start) begin
                    // A load has nothing to compute and goes straight to the emit step.
                    n_step = (i_opcode == qpe_pkg::OP_QUERY) ? uw.target
                                                             : qpe_pkg::ST_EMIT;
                end
            end
            qpe_pkg::J_WHILE_SCAN: begin
                n_step = i_status.scan_more ? r_step : uw.target;
            end
            qpe_pkg::J_WHILE_FOLD: begin
                n_step = i_status.fold_more ? r_step : uw.target;
            end
            default: begin
                n_step = qpe_pkg::ST_IDLE;
            end
        endcase
        o_ctl.accept = uw.idle & i_start;
        o_ctl.scan   = uw.scan;
        o_ctl.fold   = uw.fold;
        o_ctl.emit   = uw.emit;
        o_busy       = ~uw.idle;
    end

    property p_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_ctl.accept |=> o_busy;
    endproperty
    a_accept_busy: assert property (p_accept_busy)
        else $error("qpe_seq: not busy after a transfer was accepted");

endmodule

// File: design/qpe_datapath.sv
// ----------------------------------------------------------------------------
// qpe_datapath
// Entry RAM, span scan, sorted scope list, projection fold and result register.
// ----------------------------------------------------------------------------
module qpe_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qpe_pkg::t_ctl    i_ctl,
    input  qpe_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_wdata,
    output qpe_pkg::t_status o_status,
    output logic             o_valid,
    output qpe_pkg::t_result o_result
);

    localparam int MQ  = qpe_pkg::MAX_QUANTIFIERS;
    localparam int CW  = qpe_pkg::CNT_W;
    localparam int SW  = qpe_pkg::SPAN_W;
    localparam int CLW = qpe_pkg::CLS_W;

    logic [3:0]                  r_qcount;
    logic [CW-1:0]               n_limit;
    logic                        r_op;
    logic [qpe_pkg::TOK_W-1:0]   r_tok;
    logic [qpe_pkg::REL_W-1:0]   r_rel;
    logic                        r_end;
    logic [CW-1:0]               r_idx;
    logic                        r_pend;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_k;
    logic [SW-1:0]               r_ldist [MQ];
    logic [CLW-1:0]              r_lcls  [MQ];
    logic                        r_out_valid;
    qpe_pkg::t_result            r_result;

    logic                        ram_we;
    logic [qpe_pkg::ENTRY_W-1:0] ram_wdata;
    logic [qpe_pkg::ENTRY_W-1:0] ram_rdata;

    logic [SW-1:0]  sb, se, ob, oe, tok6;
    logic [CLW-1:0] cls_s, cls_o;
    logic           tok_ok, in_s, in_o, ev_hit;
    logic [SW-1:0]  da, db, ev_dist;
    logic [CLW-1:0] ev_cls;
    logic [MQ-1:0]  keep;
    logic [SW-1:0]  ins_dist [MQ];
    logic [CLW-1:0] ins_cls  [MQ];
    logic           is_inverting;

    // A count above the table depth acts as the depth.
    assign n_limit = ({1'b0, r_qcount} > 5'(MQ)) ? CW'(MQ) : CW'(r_qcount);

    assign ram_we = i_ctl.accept && (i_item.opcode == qpe_pkg::OP_LOAD)
                    && ({1'b0, i_item.entry_slot} < 4'(MQ));
    assign ram_wdata = {i_item.object_class, i_item.subject_class,
                        i_item.object_end, i_item.object_begin,
                        i_item.subject_end, i_item.subject_begin};

    qpe_ram #(
        .WIDTH (qpe_pkg::ENTRY_W),
        .DEPTH (MQ)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_item.entry_slot[qpe_pkg::IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[qpe_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_status.scan_more = i_ctl.scan && (r_idx < n_limit);
    assign o_status.fold_more = i_ctl.fold && (r_k < r_count);

    // Span test of the entry read in the previous cycle.
    always_comb begin
        {cls_o, cls_s, oe, ob, se, sb} = ram_rdata;
        tok6    = {1'b0, r_tok};
        tok_ok  = ({2'b00, r_tok} < 7'(qpe_pkg::MAX_TOKENS));
        in_s    = tok_ok && (tok6 >= sb) && (tok6 < se);
        in_o    = tok_ok && !in_s && (tok6 >= ob) && (tok6 < oe);
        ev_hit  = r_pend && (in_s || in_o);
        da      = in_s ? (tok6 - sb) : (tok6 - ob);
        db      = in_s ? (se - tok6) : (oe - tok6);
        ev_dist = (da < db) ? da : db;
        ev_cls  = in_s ? cls_s : cls_o;
    end

    // Stable insert: the new entry goes behind every entry at equal distance.
    always_comb begin
        for (int j = 0; j < MQ; j++) begin
            keep[j] = (CW'(j) < r_count) && (r_ldist[j] <= ev_dist);
        end
        ins_dist[0] = keep[0] ? r_ldist[0] : ev_dist;
        ins_cls[0]  = keep[0] ? r_lcls[0]  : ev_cls;
        for (int j = 1; j < MQ; j++) begin
            if (keep[j]) begin
                ins_dist[j] = r_ldist[j];
                ins_cls[j]  = r_lcls[j];
            end else if (keep[j-1]) begin
                ins_dist[j] = ev_dist;
                ins_cls[j]  = ev_cls;
            end else begin
                ins_dist[j] = r_ldist[j-1];
                ins_cls[j]  = r_lcls[j-1];
            end
        end
    end

    assign is_inverting = (r_rel == qpe_pkg::REL_NEGATION)
                       || (r_rel == qpe_pkg::REL_ALTERNATION)
                       || (r_rel == qpe_pkg::REL_COVER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcount    <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qcount <= i_cfg_wdata;
            end
            if (i_ctl.accept) begin
                r_idx   <= '0;
                r_count <= '0;
                r_k     <= '0;
            end
            if (o_status.scan_more) begin
                r_idx <= r_idx + 1'b1;
            end
            r_pend <= o_status.scan_more;
            if (ev_hit) begin
                r_count <= r_count + 1'b1;
            end
            if (o_status.fold_more) begin
                r_k <= r_k + 1'b1;
            end
            r_out_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_op  <= i_item.opcode;
            r_tok <= i_item.token_position;
            r_rel <= (i_item.lexical_relation > qpe_pkg::REL_INDEP) ? qpe_pkg::REL_INDEP
                                                                 : i_item.lexical_relation;
            r_end <= i_item.end_truth;
        end
        if (ev_hit) begin
            for (int j = 0; j < MQ; j++) begin
                r_ldist[j] <= ins_dist[j];
                r_lcls[j]  <= ins_cls[j];
            end
        end else if (o_status.fold_more) begin
            // Fold the head of the list and move the rest up one place.
            r_rel <= qpe_pkg::proj_apply(r_lcls[0], r_rel);
            for (int j = 0; j < MQ - 1; j++) begin
                r_ldist[j] <= r_ldist[j+1];
                r_lcls[j]  <= r_lcls[j+1];
            end
        end
        if (i_ctl.emit) begin
            if (r_op == qpe_pkg::OP_QUERY) begin
                r_result.projected_relation <= r_rel;
                r_result.begin_truth        <= r_end ^ is_inverting;
                r_result.scope_count        <= 4'(r_count);
            end else begin
                r_result <= '0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(MQ);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("qpe_datapath: scope count exceeds table depth");

    property p_fold_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_k <= r_count;
    endproperty
    a_fold_bound: assert property (p_fold_bound)
        else $error("qpe_datapath: fold ran past the scope list");

    property p_load_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && (r_op == qpe_pkg::OP_LOAD)) |-> (r_result == '0);
    endproperty
    a_load_zero: assert property (p_load_zero)
        else $error("qpe_datapath: load result is not zero");

    property p_accept_clear;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_ctl.accept |=> (!r_pend && (r_count == '0) && (r_idx == '0));
    endproperty
    a_accept_clear: assert property (p_accept_clear)
        else $error("qpe_datapath: scan state not cleared on a new transfer");

endmodule

// File: design/quantifier_projection_engine.sv
// ----------------------------------------------------------------------------
// quantifier_projection_engine
// Natural logic monotonicity projection of a lexical relation through the
// quantifiers whose spans hold a token.
// ----------------------------------------------------------------------------
// Usage. A command transfer is taken at a rising edge where start is high and
// busy is low; i_item carries the command. A load (opcode 0) writes one entry
// of spans and classes, skips the scan and fold steps and answers with an
// all-zero result. A query (opcode 1) scans the first quantifier_count
// entries, keeps the in-scope ones in a list sorted by edge distance, then
// folds the relation through one projection table lookup per list entry.
// A query passes the scan step, which reads the first N entries, where N is the
// effective quantifier count (at most 8), and then drains the registered read;
// the fold step, which folds through each entry in scope and then
// leaves the loop; and the emit step, which registers the result for output.
// Busy is high from the cycle after a transfer until the result cycle, in
// which the next command may already be taken.
// Each result shows on o_result for exactly one cycle with o_valid high; the
// receiver cannot stall and must take it then.
// The user must write the quantifier_count register (i_cfg_we/i_cfg_wdata)
// while the block is idle, which it does not check. Reset clears the count
// and the sequencer; entries must be loaded before a query may consider them.
// ----------------------------------------------------------------------------
module quantifier_projection_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  qpe_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_wdata,
    output logic             o_valid,
    output qpe_pkg::t_result o_result
);

    // Control strobes decoded from the current microcode word.
    qpe_pkg::t_ctl    ctl;
    // Loop conditions that the sequencer's conditional jumps test.
    qpe_pkg::t_status status;

    qpe_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    // The datapath holds the entry RAM, the sorted scope list and the result
    // register; all its work but count writes is paced by the sequencer strobes.
    qpe_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quantifier_projection_engine. Loads and queries are
// sent over the start/busy handshake. A scoreboard keeps its own copy of the
// entry store and the quantifier count, predicts every result from that copy,
// and checks each strobed result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_GAP      = 14;
    localparam int PHASE_ITEMS  = 96;
    localparam int NUM_PHASES   = 5;
    // Longest query: eight entries scanned, eight folds, plus the other sequencer steps.
    localparam int DRAIN_CYCLES = 24;

    // Projection of each relation (column) through each projectivity class
    // (row). Rows 0-3 are upward none/additive/multiplicative/both, rows 4-7
    // the downward classes in the same order, row 8 is flat.
    localparam logic [2:0] FOLD_TABLE [0:8][0:6] = '{
        '{3'd0, 3'd1, 3'd2, 3'd6, 3'd6, 3'd6, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd5, 3'd6, 3'd5, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd4, 3'd4, 3'd6, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd6, 3'd6, 3'd6, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd4, 3'd6, 3'd4, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd5, 3'd5, 3'd6, 3'd6},
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd5, 3'd4, 3'd6},
        '{3'd0, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6}
    };

    // The scoreboard mirrors the entry store and the count register. Every
    // accepted command produces exactly one expected result, so the queue of
    // predictions stays in the same order as the strobed results.
    class projection_checker;
        logic [qpe_pkg::SPAN_W-1:0] subj_lo [qpe_pkg::MAX_QUANTIFIERS];
        logic [qpe_pkg::SPAN_W-1:0] subj_hi [qpe_pkg::MAX_QUANTIFIERS];
        logic [qpe_pkg::SPAN_W-1:0] obj_lo  [qpe_pkg::MAX_QUANTIFIERS];
        logic [qpe_pkg::SPAN_W-1:0] obj_hi  [qpe_pkg::MAX_QUANTIFIERS];
        logic [qpe_pkg::CLS_W-1:0]  subj_cls[qpe_pkg::MAX_QUANTIFIERS];
        logic [qpe_pkg::CLS_W-1:0]  obj_cls [qpe_pkg::MAX_QUANTIFIERS];
        logic [3:0]                 quantifier_count;
        qpe_pkg::t_result           expected_results[$];
        int                         failures;

        function new();
            for (int i = 0; i < qpe_pkg::MAX_QUANTIFIERS; i++) begin
                subj_lo[i] = '0;
                subj_hi[i] = '0;
                obj_lo[i] = '0;
                obj_hi[i] = '0;
                subj_cls[i] = '0;
                obj_cls[i] = '0;
            end
            quantifier_count = '0;
            failures = 0;
        endfunction

        function void set_count(logic [3:0] value);
            quantifier_count = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Appends one prediction behind all earlier ones.
        function void enqueue(qpe_pkg::t_result value);
            expected_results = {expected_results, value};
        endfunction

        // One projection step; unknown classes act as flat.
        function logic [qpe_pkg::REL_W-1:0] fold(logic [qpe_pkg::CLS_W-1:0] cls,
                                                 logic [qpe_pkg::REL_W-1:0] rel);
            logic [qpe_pkg::CLS_W-1:0] c;
            c = (cls > qpe_pkg::CLASS_FLAT) ? qpe_pkg::CLASS_FLAT : cls;
            return FOLD_TABLE[c][rel];
        endfunction

        function qpe_pkg::t_result project(qpe_pkg::t_item it);
            int                        limit;
            int                        tok;
            int                        best;
            bit                        in_scope [qpe_pkg::MAX_QUANTIFIERS];
            bit                        in_subj  [qpe_pkg::MAX_QUANTIFIERS];
            int                        edge_gap [qpe_pkg::MAX_QUANTIFIERS];
            logic [qpe_pkg::REL_W-1:0] rel;
            logic [qpe_pkg::CLS_W-1:0] cls;
            qpe_pkg::t_result          r;
            limit = (quantifier_count > qpe_pkg::MAX_QUANTIFIERS)
                    ? qpe_pkg::MAX_QUANTIFIERS : int'(quantifier_count);
            tok = int'(it.token_position);
            rel = (it.lexical_relation > qpe_pkg::REL_INDEP) ? qpe_pkg::REL_INDEP
                                                              : it.lexical_relation;
            r = '0;
            for (int i = 0; i < qpe_pkg::MAX_QUANTIFIERS; i++) begin
                in_scope[i] = 1'b0;
                in_subj[i] = 1'b0;
                edge_gap[i] = 0;
                if (i < limit && tok < qpe_pkg::MAX_TOKENS) begin
                    // The subject span wins when both spans hold the token.
                    if (tok >= int'(subj_lo[i]) && tok < int'(subj_hi[i])) begin
                        in_scope[i] = 1'b1;
                        in_subj[i] = 1'b1;
                        edge_gap[i] = (tok - int'(subj_lo[i]) < int'(subj_hi[i]) - tok)
                                      ? tok - int'(subj_lo[i]) : int'(subj_hi[i]) - tok;
                    end else if (tok >= int'(obj_lo[i]) && tok < int'(obj_hi[i])) begin
                        in_scope[i] = 1'b1;
                        edge_gap[i] = (tok - int'(obj_lo[i]) < int'(obj_hi[i]) - tok)
                                      ? tok - int'(obj_lo[i]) : int'(obj_hi[i]) - tok;
                    end
                end
                if (in_scope[i]) r.scope_count = r.scope_count + 1'b1;
            end
            // Nearest edge first; a strict compare leaves ties to the lower entry.
            forever begin
                best = -1;
                for (int i = 0; i < qpe_pkg::MAX_QUANTIFIERS; i++) begin
                    if (in_scope[i] && (best < 0 || edge_gap[i] < edge_gap[best])) best = i;
                end
                if (best < 0) break;
                in_scope[best] = 1'b0;
                cls = in_subj[best] ? subj_cls[best] : obj_cls[best];
                rel = fold(cls, rel);
            end
            r.projected_relation = rel;
            r.begin_truth = it.end_truth;
            if (rel == qpe_pkg::REL_NEGATION || rel == qpe_pkg::REL_ALTERNATION
                || rel == qpe_pkg::REL_COVER) begin
                r.begin_truth = ~it.end_truth;
            end
            return r;
        endfunction

        // Called for every command the block takes.
        function void note(qpe_pkg::t_item it);
            if (it.opcode == qpe_pkg::OP_LOAD) begin
                subj_lo[it.entry_slot] = it.subject_begin;
                subj_hi[it.entry_slot] = it.subject_end;
                obj_lo[it.entry_slot] = it.object_begin;
                obj_hi[it.entry_slot] = it.object_end;
                subj_cls[it.entry_slot] = it.subject_class;
                obj_cls[it.entry_slot] = it.object_class;
                enqueue('0);
            end else begin
                enqueue(project(it));
            end
        endfunction

        function void check(qpe_pkg::t_result actual);
            qpe_pkg::t_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: relation %0d truth %0d scope %0d",
                         $time, actual.projected_relation, actual.begin_truth,
                         actual.scope_count);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (actual.projected_relation !== want.projected_relation) begin
                $display("%0t: projected_relation mismatch: expected %0d, actual %0d",
                         $time, want.projected_relation, actual.projected_relation);
                failures++;
            end
            if (actual.begin_truth !== want.begin_truth) begin
                $display("%0t: begin_truth mismatch: expected %0d, actual %0d",
                         $time, want.begin_truth, actual.begin_truth);
                failures++;
            end
            if (actual.scope_count !== want.scope_count) begin
                $display("%0t: scope_count mismatch: expected %0d, actual %0d",
                         $time, want.scope_count, actual.scope_count);
                failures++;
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    qpe_pkg::t_item   i_item      = '0;
    logic             i_cfg_we    = 1'b0;
    logic [3:0]       i_cfg_wdata = '0;
    logic             o_valid;
    qpe_pkg::t_result o_result;

    projection_checker sb = new();
    int                idle_cycles = 0;
    bit                burst_mode  = 1'b0;

    always #1 i_clk = ~i_clk;

    quantifier_projection_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // Outputs are sampled at the falling edge, where they are stable. A result
    // seen here is taken by the rising edge that closes its cycle. The same
    // sampling point feeds the watchdog: it counts cycles in which neither a
    // command transfer nor a result transfer happens.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) sb.check(o_result);
            if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired, no transfer in %0d cycles", $time,
                         STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Sends one command, waiting gap cycles with start low first. Called and
    // returns at a rising edge; on return the command has just been taken and
    // start is still high, so a back-to-back command only updates the item.
    // The transfer is known at the falling edge before it happens, because
    // start and busy only move at rising edges.
    task automatic send_command(input qpe_pkg::t_item it, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
        sb.note(it);
        @(posedge i_clk);
    endtask

    // Holds the sender off until every predicted result has been checked.
    task automatic wait_for_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // The count register is only written while the block is idle.
    task automatic write_count(input logic [3:0] value);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_count(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 4'($urandom_range(0, 15));
        @(posedge i_clk);
    endtask

    // Every field is filled with random bits first, so that the fields a
    // command does not use still toggle.
    function automatic qpe_pkg::t_item random_bits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(qpe_pkg::t_item)-1:0];
    endfunction

    function automatic qpe_pkg::t_item load_item(input int slot, input int sb_lo,
                                                 input int sb_hi, input int ob_lo,
                                                 input int ob_hi, input int s_cls,
                                                 input int o_cls);
        qpe_pkg::t_item it;
        it = random_bits();
        it.opcode = qpe_pkg::OP_LOAD;
        it.entry_slot = 3'(slot);
        it.subject_begin = 6'(sb_lo);
        it.subject_end = 6'(sb_hi);
        it.object_begin = 6'(ob_lo);
        it.object_end = 6'(ob_hi);
        it.subject_class = 4'(s_cls);
        it.object_class = 4'(o_cls);
        return it;
    endfunction

    function automatic qpe_pkg::t_item query_item(input int tok, input int rel,
                                                  input bit truth);
        qpe_pkg::t_item it;
        it = random_bits();
        it.opcode = qpe_pkg::OP_QUERY;
        it.token_position = 5'(tok);
        it.lexical_relation = 3'(rel);
        it.end_truth = truth;
        return it;
    endfunction

    // Most loads carry proper spans inside the sentence and known classes, so
    // that queries see several quantifiers in scope. The rest is raw noise:
    // reversed or oversized spans and unknown class codes.
    function automatic qpe_pkg::t_item random_load();
        qpe_pkg::t_item it;
        int             lo;
        int             hi;
        it = random_bits();
        it.opcode = qpe_pkg::OP_LOAD;
        if ($urandom_range(0, 99) < 85) begin
            lo = $urandom_range(0, qpe_pkg::MAX_TOKENS - 1);
            hi = $urandom_range(lo + 1, qpe_pkg::MAX_TOKENS);
            it.subject_begin = 6'(lo);
            it.subject_end = 6'(hi);
            lo = $urandom_range(0, qpe_pkg::MAX_TOKENS - 1);
            hi = $urandom_range(lo, qpe_pkg::MAX_TOKENS);
            it.object_begin = 6'(lo);
            it.object_end = 6'(hi);
            it.subject_class = 4'($urandom_range(0, 8));
            it.object_class = 4'($urandom_range(0, 8));
        end
        return it;
    endfunction

    function automatic qpe_pkg::t_item random_command();
        qpe_pkg::t_item it;
        if ($urandom_range(0, 99) < 30) begin
            it = random_load();
        end else begin
            it = random_bits();
            it.opcode = qpe_pkg::OP_QUERY;
        end
        return it;
    endfunction

    // Sender gaps run in stretches: long runs of back-to-back commands
    // alternate with runs of random gaps.
    function automatic int next_gap();
        if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
        return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    initial begin
        logic [3:0] phase_count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the count at its reset value no quantifier is considered: the
        // relation passes straight through, and the unknown relation code
        // comes out as independence.
        send_command(query_item(0, 7, 1'b1), next_gap());
        send_command(query_item(31, 3, 1'b0), next_gap());

        // Fill every entry before any query may consider it. The set covers
        // a sentence-wide span, reversed and empty spans, a span reaching the
        // top code, unknown classes, and two entries with identical subject
        // spans so that distance ties occur.
        send_command(load_item(0,  0, 32,  0,  0,  3,  7), next_gap());
        send_command(load_item(1,  4, 12, 12, 32,  7,  5), next_gap());
        send_command(load_item(2, 40, 10,  8, 16,  8,  2), next_gap());
        send_command(load_item(3,  6,  6,  0, 63, 15,  6), next_gap());
        send_command(load_item(4, 20, 24, 24, 28,  4,  1), next_gap());
        send_command(load_item(5,  4, 12, 63, 63,  0,  9), next_gap());
        send_command(load_item(6, 31, 32,  0,  1, 11,  3), next_gap());
        send_command(load_item(7, 63,  0, 16, 48, 13, 14), next_gap());

        write_count(4'd8);
        // Every relation code, both truth values, and tokens at the sentence
        // edges, inside the tied spans and in the object-only spans.
        for (int rel = 0; rel < 8; rel++) begin
            send_command(query_item((rel * 5) % qpe_pkg::MAX_TOKENS, rel, rel[0]),
                         next_gap());
        end
        send_command(query_item(31, 4, 1'b1), next_gap());
        send_command(query_item(8, 5, 1'b0), next_gap());
        send_command(query_item(25, 3, 1'b1), next_gap());
        send_command(query_item(22, 1, 1'b0), next_gap());

        // Random phases, each under its own count setting, including the top
        // code, which acts as the full store.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: phase_count = 4'd15;
                1: phase_count = 4'd1;
                2: phase_count = 4'd8;
                default: phase_count = 4'($urandom_range(0, 15));
            endcase
            write_count(phase_count);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once per phase the sender waits for the block to drain.
                if (n == PHASE_ITEMS / 2) wait_for_results();
                send_command(random_command(), next_gap());
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
design/qpe_pkg.sv
design/qpe_ram.sv
design/qpe_seq.sv
design/qpe_datapath.sv
design/quantifier_projection_engine.sv
tb/testbench.sv
